@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker file of the ranging line parser.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion sampled on the rising clock edge, switched off during reset.
`define RLPT_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("%m: assertion failed");

// Concurrent assertion sampled on the rising clock edge, active during reset as well.
`define RLPT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("%m: assertion failed");

`endif

@@ rtl/rlpt_pkg.sv @@
// Shared constants, codes and types of the ranging line parser and tracker.
package rlpt_pkg;

    localparam int NUM_ANCHORS_DEF = 6;
    localparam int MAX_LINE_DEF    = 1024;
    localparam int RANGE_BITS_DEF  = 24;
    localparam int FIFO_DEPTH_DEF  = 2;

    localparam int CNT_W    = 7;
    localparam int ID_W     = 4;
    localparam int CM_W     = 21;
    localparam int STATUS_W = 3;
    localparam int BYTE_W   = 8;

    localparam logic [CNT_W-1:0] LIMIT_RESET   = 7'd100;
    localparam logic [ID_W-1:0]  PREV_ID_RESET = 4'd15;

    localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
    localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
    localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;
    localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
    localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_COMMA = 3'd1,
        ST_TOO_FEW   = 3'd2,
        ST_EXTRA     = 3'd3,
        ST_OVERLONG  = 3'd4,
        ST_NO_ANCHOR = 3'd5
    } t_status;

endpackage

@@ rtl/rlpt_fifo.sv @@
// Small first-in first-out queue of words with full and empty flags.
module rlpt_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rdata,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_full  = (r_count == CNT_FULL);
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_rdata = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_LAST) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_LAST) ? '0 : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

@@ rtl/rlpt_front.sv @@
// Line parser front end: takes one byte a cycle and emits one line record per newline.
module rlpt_front #(
    parameter int NUM_ANCHORS = rlpt_pkg::NUM_ANCHORS_DEF,
    parameter int MAX_LINE    = rlpt_pkg::MAX_LINE_DEF,
    parameter int RANGE_BITS  = rlpt_pkg::RANGE_BITS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    input  logic [rlpt_pkg::BYTE_W-1:0]     i_byte,
    output logic                            o_rec_valid,
    output logic [RANGE_BITS+7:0]           o_rec
);
    import rlpt_pkg::*;

    localparam int POS_W = $clog2(MAX_LINE);
    localparam int ACC_W = RANGE_BITS;
    localparam int MUL_W = RANGE_BITS + 3;
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(MAX_LINE - 1);
    localparam logic [POS_W-1:0] POS_TWO  = POS_W'(2);
    localparam logic [ACC_W-1:0] CAP      = {1'b1, {(ACC_W-1){1'b0}}};

    typedef enum logic [2:0] {
        PH_LEAD   = 3'b001,
        PH_DIGITS = 3'b010,
        PH_DONE   = 3'b100
    } t_phase;

    logic [POS_W-1:0]  r_pos,    n_pos;
    logic [1:0]        r_tok,    n_tok;
    logic              r_in_sep, n_in_sep;
    logic [BYTE_W-1:0] r_first,  n_first;
    t_phase            r_phase,  n_phase;
    logic              r_neg,    n_neg;
    logic [ACC_W-1:0]  r_acc,    n_acc;
    logic              r_fault,  n_fault;
    logic              r_ended,  n_ended;

    logic              is_nl;
    logic              do_take;
    logic              is_digit;
    logic              is_space;
    logic              is_sign;
    logic [MUL_W-1:0]  acc_mul;
    logic              first_digit;
    logic [ID_W-1:0]   line_id;
    logic              id_ok;
    logic              line_fault;
    t_status           rec_status;
    logic [ID_W-1:0]   rec_id;

    assign is_nl    = (i_byte == CH_NL);
    assign do_take  = !r_ended && (!is_nl || r_pos >= POS_TWO);
    assign is_digit = (i_byte >= CH_ZERO) && (i_byte <= CH_NINE);
    assign is_space = (i_byte == CH_SPACE) || ((i_byte >= CH_TAB) && (i_byte <= CH_CR));
    assign is_sign  = (i_byte == CH_PLUS) || (i_byte == CH_MINUS);

    always_comb begin
        n_pos    = r_pos;
        n_tok    = r_tok;
        n_in_sep = r_in_sep;
        n_first  = r_first;
        n_phase  = r_phase;
        n_neg    = r_neg;
        n_acc    = r_acc;
        n_fault  = r_fault;
        n_ended  = r_ended;
        acc_mul  = '0;
        if (i_valid && do_take) begin
            if (i_byte == CH_NUL) begin
                n_ended = 1'b1;
                if (r_pos < POS_TWO) begin
                    n_fault = 1'b1;
                end
            end else begin
                if (r_pos == '0) begin
                    n_first = i_byte;
                    if (i_byte == CH_COMMA) begin
                        n_fault = 1'b1;
                    end
                end
                if (r_pos == POS_W'(1) && i_byte != CH_COMMA) begin
                    n_fault = 1'b1;
                end
                if (i_byte == CH_COMMA) begin
                    n_in_sep = 1'b1;
                end else begin
                    if (r_pos != '0 && r_in_sep) begin
                        n_in_sep = 1'b0;
                        if (r_tok != 2'd3) begin
                            n_tok = r_tok + 2'd1;
                        end
                        if (n_tok == 2'd2) begin
                            n_phase = PH_LEAD;
                            n_neg   = 1'b0;
                            n_acc   = '0;
                        end
                    end
                    if (n_tok == 2'd2) begin
                        if (n_phase == PH_LEAD && is_space) begin
                            n_phase = PH_LEAD;
                        end else if (n_phase == PH_LEAD && is_sign) begin
                            n_neg   = (i_byte == CH_MINUS);
                            n_phase = PH_DIGITS;
                        end else if (n_phase != PH_DONE && is_digit) begin
                            acc_mul = ({3'b000, n_acc} << 3) + ({3'b000, n_acc} << 1)
                                      + MUL_W'(i_byte - CH_ZERO);
                            n_acc   = (acc_mul > MUL_W'(CAP)) ? CAP : acc_mul[ACC_W-1:0];
                            n_phase = PH_DIGITS;
                        end else begin
                            n_phase = PH_DONE;
                        end
                    end
                end
            end
        end
        if (i_valid) begin
            if (r_pos != POS_LAST) begin
                n_pos = r_pos + 1'b1;
            end
        end
    end

    assign first_digit = (n_first >= CH_ZERO) && (n_first <= CH_NINE);
    assign line_id     = first_digit ? ID_W'(n_first - CH_ZERO) : '0;
    assign id_ok       = (line_id >= ID_W'(1)) && (line_id <= ID_W'(NUM_ANCHORS));
    assign line_fault  = n_fault || (r_pos < POS_TWO);

    always_comb begin
        rec_id = line_id;
        if (r_pos == POS_LAST) begin
            rec_status = ST_OVERLONG;
            rec_id     = '0;
        end else if (line_fault) begin
            rec_status = ST_BAD_COMMA;
            rec_id     = '0;
        end else if (n_tok < 2'd2) begin
            rec_status = ST_TOO_FEW;
        end else if (n_tok > 2'd2) begin
            rec_status = ST_EXTRA;
        end else if (id_ok) begin
            rec_status = ST_OK;
        end else begin
            rec_status = ST_NO_ANCHOR;
        end
    end

    assign o_rec_valid = i_valid && is_nl;
    assign o_rec       = {rec_status, rec_id, n_neg, n_acc};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || o_rec_valid) begin
            r_pos    <= '0;
            r_tok    <= '0;
            r_in_sep <= 1'b0;
            r_first  <= '0;
            r_phase  <= PH_LEAD;
            r_neg    <= 1'b0;
            r_acc    <= '0;
            r_fault  <= 1'b0;
            r_ended  <= 1'b0;
        end else begin
            r_pos    <= n_pos;
            r_tok    <= n_tok;
            r_in_sep <= n_in_sep;
            r_first  <= n_first;
            r_phase  <= n_phase;
            r_neg    <= n_neg;
            r_acc    <= n_acc;
            r_fault  <= n_fault;
            r_ended  <= n_ended;
        end
    end

endmodule

@@ rtl/rlpt_back.sv @@
// Tracker back end: scales the range, updates the anchor counters and forms each result word.
module rlpt_back #(
    parameter int NUM_ANCHORS = rlpt_pkg::NUM_ANCHORS_DEF,
    parameter int RANGE_BITS  = rlpt_pkg::RANGE_BITS_DEF
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_cfg_wr_en,
    input  logic [rlpt_pkg::CNT_W-1:0]                i_cfg_wr_data,
    input  logic                                      i_rec_valid,
    input  logic [RANGE_BITS+7:0]                     i_rec,
    output logic                                      o_rec_pop,
    input  logic                                      i_res_full,
    output logic                                      o_res_push,
    output logic [NUM_ANCHORS*rlpt_pkg::CNT_W+29:0]   o_res
);
    import rlpt_pkg::*;

    localparam int RB    = RANGE_BITS;
    localparam int PROD_W = 2 * RB;
    localparam int Q_W   = RB - 3;
    localparam logic [RB-1:0] CAP   = {1'b1, {(RB-1){1'b0}}};
    localparam logic [RB-1:0] RECIP = RB'(((64'd1 << (RB + 3)) + 64'd9) / 64'd10);

    t_status              rec_status;
    logic [ID_W-1:0]      rec_id;
    logic                 rec_neg;
    logic [RB-1:0]        rec_acc;
    logic [RB-1:0]        mag;
    logic                 a_ready;
    logic                 a_fire;

    logic                 r_a_valid;
    t_status              r_a_status;
    logic [ID_W-1:0]      r_a_id;
    logic                 r_a_neg;
    logic [PROD_W-1:0]    r_a_prod;

    logic [CNT_W-1:0]     r_limit;
    logic [CNT_W-1:0]     r_cnt [NUM_ANCHORS];
    logic [CNT_W-1:0]     n_cnt [NUM_ANCHORS];
    logic                 r_recv,    n_recv;
    logic [ID_W-1:0]      r_prev_id, n_prev_id;

    logic                 upd;
    logic [Q_W-1:0]       quot;
    logic signed [Q_W:0]  quot_s;
    logic signed [31:0]   quot_ext;
    logic [CM_W-1:0]      cm;
    logic                 round;
    logic [NUM_ANCHORS*CNT_W-1:0] packed_cnt;

    assign rec_status = t_status'(i_rec[RB+7:RB+5]);
    assign rec_id     = i_rec[RB+4:RB+1];
    assign rec_neg    = i_rec[RB];
    assign rec_acc    = i_rec[RB-1:0];
    assign mag        = (!rec_neg && rec_acc >= CAP) ? CAP - 1'b1 : rec_acc;

    assign a_fire    = r_a_valid && !i_res_full;
    assign a_ready   = !r_a_valid || !i_res_full;
    assign o_rec_pop = i_rec_valid && a_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (a_ready) begin
            r_a_valid <= i_rec_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_rec_pop) begin
            r_a_status <= rec_status;
            r_a_id     <= rec_id;
            r_a_neg    <= rec_neg;
            r_a_prod   <= PROD_W'(mag) * PROD_W'(RECIP);
        end
    end

    assign upd      = a_fire && (r_a_status == ST_OK || r_a_status == ST_NO_ANCHOR);
    assign quot     = r_a_prod[PROD_W-1:RB+3];
    assign quot_s   = r_a_neg ? -$signed({1'b0, quot}) : $signed({1'b0, quot});
    assign quot_ext = 32'(quot_s);
    assign cm       = upd ? quot_ext[CM_W-1:0] : '0;
    assign round    = upd && (r_a_id <= r_prev_id);

    always_comb begin
        n_recv    = r_recv;
        n_prev_id = r_prev_id;
        for (int i = 0; i < NUM_ANCHORS; i++) begin
            n_cnt[i] = r_cnt[i];
        end
        if (upd) begin
            n_prev_id = r_a_id;
            if (r_a_status == ST_OK) begin
                n_recv = 1'b1;
            end
            for (int i = 0; i < NUM_ANCHORS; i++) begin
                if (r_a_status == ST_OK && r_a_id == ID_W'(i + 1)) begin
                    n_cnt[i] = '0;
                end else if (r_cnt[i] < r_limit) begin
                    n_cnt[i] = r_cnt[i] + 1'b1;
                end
            end
        end
    end

    always_comb begin
        for (int i = 0; i < NUM_ANCHORS; i++) begin
            packed_cnt[i*CNT_W +: CNT_W] = n_cnt[i];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit   <= LIMIT_RESET;
            r_recv    <= 1'b0;
            r_prev_id <= PREV_ID_RESET;
            for (int i = 0; i < NUM_ANCHORS; i++) begin
                r_cnt[i] <= '0;
            end
        end else begin
            if (i_cfg_wr_en) begin
                r_limit <= i_cfg_wr_data;
            end
            r_recv    <= n_recv;
            r_prev_id <= n_prev_id;
            for (int i = 0; i < NUM_ANCHORS; i++) begin
                r_cnt[i] <= n_cnt[i];
            end
        end
    end

    assign o_res_push = a_fire;
    assign o_res      = {r_a_status, r_a_id, cm, round, n_recv, packed_cnt};

endmodule

@@ rtl/ranging_line_parser_tracker.sv @@
// Ranging line parser and anchor tracker, top level.
//
// Bytes of text lines "id,timestamp,range" enter on the input queue port: a byte is taken
// at a clock edge with push high and full low. Every byte but a newline is absorbed by the
// parser; a newline closes the line and yields exactly one result word on the output queue
// port, held while empty is low and taken at an edge with pop high and empty low.
// The block takes one byte every cycle while full is low. A result word passes from its
// newline through the line record queue and the multiplier stage that scales the range by
// a tenth, then waits at the head of the result queue. The back end retires one line per
// cycle while the result queue has room, so newlines may follow one another with no gap.
// If the receiver stalls, results collect in the two-entry result queue, then the scaling
// stage and the two-entry record queue fill; full rises only when the record queue is full,
// so at most five lines are in flight before input is held back.
// The absence limit register may be written whenever the block is idle.
// A synchronous low reset empties both queues, clears the line parser, the absence
// counters and the receiving flag, sets the limit to 100 and the previous id to fifteen.
module ranging_line_parser_tracker #(
    parameter int NUM_ANCHORS = rlpt_pkg::NUM_ANCHORS_DEF,
    parameter int MAX_LINE    = rlpt_pkg::MAX_LINE_DEF,
    parameter int RANGE_BITS  = rlpt_pkg::RANGE_BITS_DEF,
    parameter int FIFO_DEPTH  = rlpt_pkg::FIFO_DEPTH_DEF
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    push,
    output logic                                    full,
    input  logic [rlpt_pkg::BYTE_W-1:0]             i_rx_byte,
    output logic                                    empty,
    input  logic                                    pop,
    output logic [rlpt_pkg::STATUS_W-1:0]           o_line_status,
    output logic [rlpt_pkg::ID_W-1:0]               o_anchor_id,
    output logic signed [rlpt_pkg::CM_W-1:0]        o_range_cm,
    output logic                                    o_round_complete,
    output logic                                    o_receiving,
    output logic [NUM_ANCHORS*rlpt_pkg::CNT_W-1:0]  o_absence_counts,
    input  logic                                    i_cfg_wr_en,
    input  logic [rlpt_pkg::CNT_W-1:0]              i_cfg_wr_data
);
    import rlpt_pkg::*;

    localparam int REC_W = RANGE_BITS + 8;
    localparam int CB    = NUM_ANCHORS * CNT_W;
    localparam int RES_W = CB + 30;

    logic             in_fire;
    logic             rec_push;
    logic [REC_W-1:0] rec_wdata;
    logic [REC_W-1:0] rec_rdata;
    logic             rec_full;
    logic             rec_empty;
    logic             rec_pop;
    logic             res_push;
    logic [RES_W-1:0] res_wdata;
    logic [RES_W-1:0] res_rdata;
    logic             res_full;

    assign full    = rec_full;
    assign in_fire = push && !rec_full;

    rlpt_front #(
        .NUM_ANCHORS (NUM_ANCHORS),
        .MAX_LINE    (MAX_LINE),
        .RANGE_BITS  (RANGE_BITS)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (in_fire),
        .i_byte      (i_rx_byte),
        .o_rec_valid (rec_push),
        .o_rec       (rec_wdata)
    );

    rlpt_fifo #(
        .WIDTH (REC_W),
        .DEPTH (FIFO_DEPTH)
    ) u_rec_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (rec_push),
        .i_wdata (rec_wdata),
        .i_pop   (rec_pop),
        .o_rdata (rec_rdata),
        .o_full  (rec_full),
        .o_empty (rec_empty)
    );

    rlpt_back #(
        .NUM_ANCHORS (NUM_ANCHORS),
        .RANGE_BITS  (RANGE_BITS)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rec_valid   (!rec_empty),
        .i_rec         (rec_rdata),
        .o_rec_pop     (rec_pop),
        .i_res_full    (res_full),
        .o_res_push    (res_push),
        .o_res         (res_wdata)
    );

    rlpt_fifo #(
        .WIDTH (RES_W),
        .DEPTH (FIFO_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_wdata (res_wdata),
        .i_pop   (pop),
        .o_rdata (res_rdata),
        .o_full  (res_full),
        .o_empty (empty)
    );

    assign o_line_status    = res_rdata[CB+29:CB+27];
    assign o_anchor_id      = res_rdata[CB+26:CB+23];
    assign o_range_cm       = res_rdata[CB+22:CB+2];
    assign o_round_complete = res_rdata[CB+1];
    assign o_receiving      = res_rdata[CB];
    assign o_absence_counts = res_rdata[CB-1:0];

endmodule

@@ rtl/rlpt_checker.sv @@
// Port-level assertion checker for the ranging line parser and tracker, with its binding.
`include "assert_macros.svh"

module rlpt_checker #(
    parameter int NUM_ANCHORS = rlpt_pkg::NUM_ANCHORS_DEF
) (
    input logic                                    i_clk,
    input logic                                    i_rst_n,
    input logic                                    empty,
    input logic                                    pop,
    input logic [rlpt_pkg::STATUS_W-1:0]           o_line_status,
    input logic [rlpt_pkg::ID_W-1:0]               o_anchor_id,
    input logic signed [rlpt_pkg::CM_W-1:0]        o_range_cm,
    input logic                                    o_round_complete,
    input logic                                    o_receiving,
    input logic [NUM_ANCHORS*rlpt_pkg::CNT_W-1:0]  o_absence_counts
);
    import rlpt_pkg::*;

    // No result may be offered in the cycle after reset.
    `RLPT_ASSERT_ALWAYS(a_empty_after_reset, i_clk, !i_rst_n |=> empty)

    // Once a result reports receiving, every later result does too.
    `RLPT_ASSERT(a_receiving_sticky, i_clk, i_rst_n, (!empty && o_receiving) |=> (empty || o_receiving))

    // A good line always sets the receiving flag.
    `RLPT_ASSERT(a_ok_receiving, i_clk, i_rst_n, (!empty && o_line_status == ST_OK) |-> o_receiving)

    // Framing faults carry no anchor, no range and no round trigger.
    `RLPT_ASSERT(a_fault_clean, i_clk, i_rst_n, (!empty && (o_line_status == ST_BAD_COMMA || o_line_status == ST_OVERLONG)) |-> (o_anchor_id == '0 && o_range_cm == '0 && !o_round_complete))

    // A stalled result word holds still.
    `RLPT_ASSERT(a_stall_hold, i_clk, i_rst_n, (!empty && !pop) |=> (!empty && $stable(o_line_status) && $stable(o_absence_counts)))

endmodule

bind ranging_line_parser_tracker rlpt_checker #(
    .NUM_ANCHORS (NUM_ANCHORS)
) u_rlpt_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .empty            (empty),
    .pop              (pop),
    .o_line_status    (o_line_status),
    .o_anchor_id      (o_anchor_id),
    .o_range_cm       (o_range_cm),
    .o_round_complete (o_round_complete),
    .o_receiving      (o_receiving),
    .o_absence_counts (o_absence_counts)
);

@@ tb/ranging_line_parser_tracker_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench for the ranging line parser and anchor tracker, with a line predictor.
module ranging_line_parser_tracker_test;
    import rlpt_pkg::*;

    localparam int ANCHORS       = NUM_ANCHORS_DEF;
    localparam int LINE_MAX      = MAX_LINE_DEF;
    localparam int RBITS         = RANGE_BITS_DEF;
    localparam int COUNTS_W      = ANCHORS * CNT_W;
    localparam int SETTLE_CYCLES = 8;
    localparam int PHASE_BYTES   = 110;

    localparam logic [1:0] NUM_LEAD   = 2'd0;
    localparam logic [1:0] NUM_DIGITS = 2'd1;
    localparam logic [1:0] NUM_DONE   = 2'd2;

    localparam logic [CNT_W-1:0] PHASE_LIMITS [6] = '{7'd127, 7'd0, 7'd3, 7'd100, 7'd1, 7'd50};

    typedef struct {
        t_status                 status;
        logic [ID_W-1:0]         anchor;
        logic signed [CM_W-1:0]  range_cm;
        logic                    round_done;
        logic                    receiving;
        logic [COUNTS_W-1:0]     counts;
    } t_line_report;

    logic                    i_clk;
    logic                    i_rst_n;
    logic                    push = 1'b0;
    logic                    full;
    logic [BYTE_W-1:0]       i_rx_byte = '0;
    logic                    empty;
    logic                    pop = 1'b0;
    logic [STATUS_W-1:0]     o_line_status;
    logic [ID_W-1:0]         o_anchor_id;
    logic signed [CM_W-1:0]  o_range_cm;
    logic                    o_round_complete;
    logic                    o_receiving;
    logic [COUNTS_W-1:0]     o_absence_counts;
    logic                    i_cfg_wr_en = 1'b0;
    logic [CNT_W-1:0]        i_cfg_wr_data = '0;

    ranging_line_parser_tracker DUT (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_rx_byte        (i_rx_byte),
        .empty            (empty),
        .pop              (pop),
        .o_line_status    (o_line_status),
        .o_anchor_id      (o_anchor_id),
        .o_range_cm       (o_range_cm),
        .o_round_complete (o_round_complete),
        .o_receiving      (o_receiving),
        .o_absence_counts (o_absence_counts),
        .i_cfg_wr_en      (i_cfg_wr_en),
        .i_cfg_wr_data    (i_cfg_wr_data)
    );

    logic [BYTE_W-1:0] rx_backlog [$];
    t_line_report      awaited_lines [$];
    int                fault_count  = 0;
    int                bytes_queued = 0;
    int                send_idle    = 0;
    int                recv_idle    = 0;
    int                next_anchor  = 1;
    bit                byte_taken   = 1'b0;

    // Predictor state.
    logic [CNT_W-1:0]  limit_model;
    int unsigned       col;
    int unsigned       field_no;
    bit                after_comma;
    logic [BYTE_W-1:0] lead_char;
    logic [1:0]        num_state;
    bit                minus;
    longint unsigned   mag;
    bit                lead_fault;
    bit                text_done;
    logic [CNT_W-1:0]  miss_count [ANCHORS];
    bit                heard;
    logic [ID_W-1:0]   last_anchor;

    function automatic bit is_blank(logic [BYTE_W-1:0] c);
        return c == CH_SPACE || (c >= CH_TAB && c <= CH_CR);
    endfunction

    task automatic start_line();
        col         = 0;
        field_no    = 0;
        after_comma = 1'b0;
        lead_char   = '0;
        num_state   = NUM_LEAD;
        minus       = 1'b0;
        mag         = 0;
        lead_fault  = 1'b0;
        text_done   = 1'b0;
    endtask

    task automatic feed_range(logic [BYTE_W-1:0] c);
        longint unsigned cap;
        longint unsigned v;
        cap = longint'(1) << (RBITS - 1);
        if (num_state == NUM_LEAD && is_blank(c)) begin
            return;
        end
        if (num_state == NUM_LEAD && (c == CH_PLUS || c == CH_MINUS)) begin
            minus     = (c == CH_MINUS);
            num_state = NUM_DIGITS;
            return;
        end
        if (num_state != NUM_DONE && c >= CH_ZERO && c <= CH_NINE) begin
            v         = mag * 10 + longint'(c - CH_ZERO);
            mag       = (v > cap) ? cap : v;
            num_state = NUM_DIGITS;
            return;
        end
        num_state = NUM_DONE;
    endtask

    task automatic absorb_char(logic [BYTE_W-1:0] c, int unsigned p);
        if (c == CH_NUL) begin
            text_done = 1'b1;
            if (p < 2) lead_fault = 1'b1;
            return;
        end
        if (p == 0) begin
            lead_char = c;
            if (c == CH_COMMA) lead_fault = 1'b1;
        end
        if (p == 1 && c != CH_COMMA) lead_fault = 1'b1;
        if (c == CH_COMMA) begin
            after_comma = 1'b1;
            return;
        end
        if (p != 0 && after_comma) begin
            after_comma = 1'b0;
            if (field_no < 3) field_no++;
            if (field_no == 2) begin
                num_state = NUM_LEAD;
                minus     = 1'b0;
                mag       = 0;
            end
        end
        if (field_no == 2) feed_range(c);
    endtask

    task automatic parse_rx_byte(logic [BYTE_W-1:0] c);
        int unsigned     p;
        int              id;
        t_line_report    r;
        longint unsigned cap;
        longint          rng;
        longint          cm;
        p = col;
        if (c != CH_NL) begin
            if (!text_done) absorb_char(c, p);
            if (col < LINE_MAX - 1) col++;
            return;
        end
        if (!text_done && p >= 2) absorb_char(c, p);
        if (p < 2) lead_fault = 1'b1;
        id           = (lead_char >= CH_ZERO && lead_char <= CH_NINE) ? lead_char - CH_ZERO : 0;
        r.anchor     = '0;
        r.range_cm   = '0;
        r.round_done = 1'b0;
        if (p >= LINE_MAX - 1) begin
            r.status = ST_OVERLONG;
        end else if (lead_fault) begin
            r.status = ST_BAD_COMMA;
        end else if (field_no < 2) begin
            r.status = ST_TOO_FEW;
            r.anchor = id[ID_W-1:0];
        end else if (field_no > 2) begin
            r.status = ST_EXTRA;
            r.anchor = id[ID_W-1:0];
        end else begin
            r.anchor = id[ID_W-1:0];
            r.status = (id >= 1 && id <= ANCHORS) ? ST_OK : ST_NO_ANCHOR;
            cap = longint'(1) << (RBITS - 1);
            if (minus) rng = -longint'(mag);
            else rng = (mag >= cap) ? cap - 1 : mag;
            cm = rng / 10;
            r.range_cm = cm[CM_W-1:0];
            for (int i = 0; i < ANCHORS; i++) begin
                if (r.status == ST_OK && i == id - 1) begin
                    miss_count[i] = '0;
                    heard = 1'b1;
                end else if (miss_count[i] < limit_model) begin
                    miss_count[i]++;
                end
            end
            r.round_done = (id[ID_W-1:0] <= last_anchor);
            last_anchor  = id[ID_W-1:0];
        end
        r.receiving = heard;
        for (int i = 0; i < ANCHORS; i++) r.counts[i*CNT_W +: CNT_W] = miss_count[i];
        awaited_lines.push_back(r);
        start_line();
    endtask

    task automatic push_rx(logic [BYTE_W-1:0] b);
        rx_backlog.push_back(b);
        bytes_queued++;
    endtask

    task automatic queue_text(string s);
        for (int i = 0; i < s.len(); i++) push_rx(s[i]);
    endtask

    // A line of body_len bytes before its newline, filled with digits or random bytes.
    task automatic queue_long_line(int body_len, bit noisy);
        logic [BYTE_W-1:0] b;
        queue_text("1,2,");
        for (int i = 4; i < body_len; i++) begin
            b = noisy ? 8'($urandom_range(255)) : CH_NINE;
            if (b == CH_NL) b = CH_SPACE;
            push_rx(b);
        end
        push_rx(CH_NL);
    endtask

    task automatic queue_random_line();
        logic [BYTE_W-1:0] line_buf [$];
        logic [BYTE_W-1:0] ch;
        int                kind;
        int                n;
        int                pos;
        kind = $urandom_range(99);
        if (kind >= 88) begin
            n = $urandom_range(14);
            repeat (n) line_buf.push_back(8'($urandom_range(255)));
        end else begin
            if ($urandom_range(99) < 85) begin
                if ($urandom_range(9) == 0) next_anchor = $urandom_range(1, ANCHORS);
                ch = CH_ZERO + 8'(next_anchor);
                next_anchor = next_anchor % ANCHORS + 1;
            end else begin
                ch = CH_ZERO + 8'($urandom_range(9));
            end
            line_buf.push_back(ch);
            repeat (($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1)
                line_buf.push_back(CH_COMMA);
            n = $urandom_range(1, 6);
            repeat (n) line_buf.push_back(($urandom_range(9) == 0) ?
                8'($urandom_range(8'h21, 8'h7E)) : CH_ZERO + 8'($urandom_range(9)));
            repeat (($urandom_range(3) == 0) ? $urandom_range(2, 4) : 1)
                line_buf.push_back(CH_COMMA);
            if ($urandom_range(3) == 0) begin
                repeat ($urandom_range(1, 2)) begin
                    case ($urandom_range(4))
                        0: line_buf.push_back(CH_SPACE);
                        1: line_buf.push_back(CH_TAB);
                        2: line_buf.push_back(CH_CR);
                        3: line_buf.push_back(8'h0B);
                        default: line_buf.push_back(8'h0C);
                    endcase
                end
            end
            case ($urandom_range(3))
                0: line_buf.push_back(CH_PLUS);
                1: line_buf.push_back(CH_MINUS);
                default: ;
            endcase
            n = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(0, 6);
            repeat (n) line_buf.push_back(CH_ZERO + 8'($urandom_range(9)));
            if ($urandom_range(9) == 0) line_buf.push_back(8'($urandom_range(8'h21, 8'h7E)));
            if (kind >= 70) begin
                pos = $urandom_range(line_buf.size() - 1);
                case ($urandom_range(3))
                    0: line_buf[pos] = 8'($urandom_range(255));
                    1: line_buf.insert(pos, CH_COMMA);
                    2: line_buf.insert(pos, CH_NUL);
                    default: while (line_buf.size() > pos) void'(line_buf.pop_back());
                endcase
            end
        end
        foreach (line_buf[i]) push_rx(line_buf[i]);
        push_rx(CH_NL);
    endtask

    task automatic wait_quiet();
        do @(negedge i_clk);
        while (rx_backlog.size() != 0 || awaited_lines.size() != 0);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_limit(logic [CNT_W-1:0] value);
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en <= 1'b0;
        limit_model = value;
    endtask

    task automatic check_field(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $display("%0t: %s expected %0d, got %0d", $time, name, $signed(want), $signed(got));
            fault_count++;
        end
    endtask

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Sender: a byte is held until it is taken.
    always @(posedge i_clk) begin
        byte_taken = i_rst_n && push && !full;
        if (byte_taken) begin
            parse_rx_byte(i_rx_byte);
            void'(rx_backlog.pop_front());
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            push <= 1'b0;
        end else if (push && !byte_taken) begin
            push <= 1'b1;
        end else if (rx_backlog.size() != 0 && $urandom_range(99) >= send_idle) begin
            push      <= 1'b1;
            i_rx_byte <= rx_backlog[0];
        end else begin
            push <= 1'b0;
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) pop <= 1'b0;
        else pop <= ($urandom_range(99) >= recv_idle);
    end

    always @(posedge i_clk) begin
        t_line_report r;
        if (i_rst_n && pop && !empty) begin
            if (awaited_lines.size() == 0) begin
                $display("%0t: result word with no line awaited, expected none, got status %0d",
                         $time, o_line_status);
                fault_count++;
            end else begin
                r = awaited_lines.pop_front();
                check_field("line_status", r.status, o_line_status);
                check_field("anchor_id", r.anchor, o_anchor_id);
                check_field("range_cm", r.range_cm, o_range_cm);
                check_field("round_complete", r.round_done, o_round_complete);
                check_field("receiving", r.receiving, o_receiving);
                check_field("absence_counts", r.counts, o_absence_counts);
            end
        end
    end

    initial begin
        #3_000_000;
        $display("ranging_line_parser_tracker_test: done, errors");
        $finish;
    end

    initial begin
        i_rst_n     = 1'b0;
        limit_model = LIMIT_RESET;
        start_line();
        foreach (miss_count[i]) miss_count[i] = '0;
        heard       = 1'b0;
        last_anchor = PREV_ID_RESET;
        send_idle   = 12;
        recv_idle   = 82;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        queue_text("1,100,1234\n");
        queue_text("2,5,-8388608\n");
        queue_text("3,5,99999999999\n");
        queue_text("1,,,7,,,  +55\n");
        queue_text(",1,2,3\n");
        queue_text("12,3,4\n");
        queue_text("\n");
        queue_text("5,7\n");
        queue_text("5,7,8,9\n");
        queue_text("5,1,,,,\n");
        queue_text("0,1,2\n");
        queue_text("9,1,2\n");
        queue_text("x,1,2\n");
        queue_text("4,1,2");
        push_rx(CH_NUL);
        queue_text("junk,,\n");
        queue_text("4");
        push_rx(CH_NUL);
        queue_text(",1,2\n");
        push_rx(CH_NUL);
        queue_text(",1,2\n");
        queue_text("6,1,9abc\n");
        queue_text("7,1,-\n");
        queue_text("2,1, \t-0\n");
        queue_text("3,1,8388607\n");
        queue_text("6,1,-99999999999\n");
        queue_long_line(LINE_MAX - 1, 1'b1);
        queue_text("2,8,16\n");
        wait_quiet();

        for (int ph = 0; ph < 6; ph++) begin
            case (ph / 2)
                0: begin
                    send_idle = 12;
                    recv_idle = 82;
                end
                1: begin
                    send_idle = 82;
                    recv_idle = 12;
                end
                default: begin
                    send_idle = 0;
                    recv_idle = 0;
                end
            endcase
            write_limit((ph == 5) ? 7'($urandom_range(127)) : PHASE_LIMITS[ph]);
            bytes_queued = 0;
            while (bytes_queued < PHASE_BYTES) queue_random_line();
            wait_quiet();
        end

        if (fault_count == 0) begin
            $display("ranging_line_parser_tracker_test: done, clean");
        end else begin
            $display("ranging_line_parser_tracker_test: done, errors");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+rtl
rtl/rlpt_pkg.sv
rtl/rlpt_fifo.sv
rtl/rlpt_front.sv
rtl/rlpt_back.sv
rtl/ranging_line_parser_tracker.sv
rtl/rlpt_checker.sv
tb/ranging_line_parser_tracker_test.sv
